/* rtl/trms_pkg.sv */
// Shared widths and limits for the true-RMS window unit.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package trms_pkg;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int RMS_W      = 16;

   // Magnitude of a sample: 0..32768 fits 16 unsigned bits
   localparam int MAG_W      = 16;

   // One square is at most 2^30
   localparam int SQ_W       = 31;

   // Mean of squares is at most 2^30; root radicand is padded to an even width
   localparam int MEAN_W     = 31;
   localparam int RAD_W      = 32;

   // Square-root datapath: partial remainder and step count
   localparam int SQREM_W    = 17;
   localparam int ROOT_STEPS = RAD_W / 2;

   // Largest result: root of 2^30
   localparam int RMS_MAX    = 32768;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [RMS_W-1:0]           rms_type;
   typedef logic [MAG_W-1:0]           mag_type;

endpackage

`default_nettype wire

/* rtl/trms_req_if.sv */
// Sample channel: valid/ready handshake carrying one signed sample per word.
// Depends on trms_pkg.
`default_nettype none

interface trms_req_if;
   logic                  valid;
   logic                  ready;
   trms_pkg::sample_type  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* rtl/trms_rsp_if.sv */
// Result channel: valid/ready handshake carrying one RMS value per word.
// Depends on trms_pkg.
`default_nettype none

interface trms_rsp_if;
   logic               valid;
   logic               ready;
   trms_pkg::rms_type  rms_value;

   modport source (output valid, output rms_value, input ready);
   modport sink   (input valid, input rms_value, output ready);
endinterface

`default_nettype wire

/* rtl/true_rms_window_unit.sv */
// True-RMS over fixed windows of signed samples, bit-serial datapath.
// Depends on trms_pkg, trms_req_if and trms_rsp_if.
//
// Usage:
//   req_ch carries one signed 16-bit sample per word; rsp_ch carries one
//   unsigned 16-bit RMS value per window of NUM_SAMPLES samples:
//   floor(sqrt(floor(sum of squares / NUM_SAMPLES))).
//   Each sample is squared by a shift-and-add multiplier, one multiplier bit
//   per cycle, into the sum-of-squares register. A new sample word is taken
//   only once the 16 square steps of the last one are done.
//   On the last sample of a window the sum is handed to a restoring divider
//   that retires one quotient bit per cycle, then to a square-root unit that
//   retires one root bit per cycle. No sample is taken from the last sample
//   of the window until its result word is loaded into the output register.
//   The result sits in an output register; the next window's samples are
//   taken while it waits. If a new result is ready while the old one is still
//   stalled, the unit holds until the receiver takes the old word.
//   Reset (synchronous, active high) clears the sum, the sample count, the
//   sequencer and the output valid flag.
`default_nettype none

module true_rms_window_unit #(
   parameter int NUM_SAMPLES = 16
) (
   input  wire        clock,
   input  wire        reset,
   trms_req_if.sink   req_ch,
   trms_rsp_if.source rsp_ch
);

   // Window length; a setting below one is taken as one
   localparam int WIN_LEN  = (NUM_SAMPLES < 1) ? 1 : NUM_SAMPLES;

   localparam int SUM_W    = $clog2(WIN_LEN) + trms_pkg::SQ_W;
   localparam int CNT_W    = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
   localparam int RDIV_W   = $clog2(WIN_LEN) + 1;
   localparam int STEP_W   = $clog2(SUM_W);

   localparam logic [CNT_W-1:0]  LAST_CNT   = CNT_W'(WIN_LEN - 1);
   localparam logic [RDIV_W:0]   DIVISOR    = (RDIV_W + 1)'(WIN_LEN);
   localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(trms_pkg::MAG_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST  = STEP_W'(trms_pkg::ROOT_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ROOT,
      ST_LOAD
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          last_ff, last_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [trms_pkg::SQ_W-1:0]     mcand_ff, mcand_in;
   logic [trms_pkg::MAG_W-1:0]    mplier_ff, mplier_in;
   logic [SUM_W-1:0]              div_ff, div_in;
   logic [RDIV_W-1:0]             drem_ff, drem_in;
   logic [trms_pkg::RAD_W-1:0]    rad_ff, rad_in;
   logic [trms_pkg::SQREM_W-1:0]  srem_ff, srem_in;
   trms_pkg::rms_type             root_ff, root_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   trms_pkg::rms_type             rms_ff, rms_in;

   trms_pkg::mag_type             mag;
   logic [SUM_W-1:0]              sum_next;
   logic [RDIV_W:0]               dshift;
   logic                          dge;
   logic [SUM_W-1:0]              quot;
   logic [trms_pkg::SQREM_W+1:0]  tshift;
   logic [trms_pkg::SQREM_W+1:0]  trial;
   logic                          tge;

   // Magnitude of the incoming sample; the most negative sample maps to 32768
   assign mag = req_ch.sample[trms_pkg::SAMPLE_W-1]
              ? trms_pkg::MAG_W'(~req_ch.sample + 1'b1)
              : trms_pkg::MAG_W'(req_ch.sample);

   // Shift-and-add step: add the shifted multiplicand when the multiplier bit is set
   assign sum_next = mplier_ff[0] ? (sum_ff + SUM_W'(mcand_ff)) : sum_ff;

   // Restoring divide step: bring in the next dividend bit, subtract if it fits
   assign dshift = {drem_ff, div_ff[SUM_W-1]};
   assign dge    = (dshift >= DIVISOR);
   assign quot   = {div_ff[SUM_W-2:0], dge};

   // Square-root step: bring in two radicand bits, try (root << 2) | 1
   assign tshift = {srem_ff, rad_ff[trms_pkg::RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign tge    = (tshift >= trial);

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.rms_value = rms_ff;

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      div_in       = div_ff;
      drem_in      = drem_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff;
      rms_in       = rms_ff;

      // Drop the result word once the receiver takes it
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mcand_in  = trms_pkg::SQ_W'(mag);
               mplier_in = mag;
               step_in   = '0;
               last_in   = (count_ff == LAST_CNT);
               count_in  = (count_ff == LAST_CNT) ? '0 : count_ff + 1'b1;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            sum_in    = sum_next;
            if (step_ff == MUL_LAST) begin
               step_in = '0;
               if (last_ff) begin
                  // Hand the window sum to the divider and clear for the next window
                  div_in   = sum_next;
                  drem_in  = '0;
                  sum_in   = '0;
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIVIDE: begin
            drem_in = dge ? RDIV_W'(dshift - DIVISOR) : RDIV_W'(dshift);
            div_in  = quot;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               rad_in   = {1'b0, quot[trms_pkg::MEAN_W-1:0]};
               srem_in  = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            srem_in = tge ? trms_pkg::SQREM_W'(tshift - trial)
                          : trms_pkg::SQREM_W'(tshift);
            root_in = {root_ff[trms_pkg::RMS_W-2:0], tge};
            rad_in  = rad_ff << 2;
            step_in = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rms_in       = root_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         step_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      div_ff    <= div_in;
      drem_ff   <= drem_in;
      rad_ff    <= rad_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      rms_ff    <= rms_in;
   end

   // Sample count stays inside the window
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_CNT)
      else $error("sample count beyond window length");

   // Divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> ({1'b0, drem_ff} < DIVISOR))
      else $error("divider remainder out of range");

   // A result word never exceeds the root of the largest mean
   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rms_ff <= trms_pkg::RMS_W'(trms_pkg::RMS_MAX)))
      else $error("result word out of range");

   // An accepted sample occupies the datapath in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("sample taken while squaring");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for true_rms_window_unit: a sample table, then random windows.
// Each sample word is run through an in-bench RMS predictor; result words are compared in order.
// Depends on trms_pkg, trms_req_if, trms_rsp_if and the unit itself.

module tb_top;

   localparam int WIN         = 16;      // window length handed to the unit
   localparam int RAND_ITEMS  = 1700;
   localparam int IDLE_PCT    = 37;
   localparam int LIMIT       = 400000;  // cycles; the run is stopped as a failure past this bound
   localparam int DRAIN       = 200;     // cycles to let the pipe settle after the last result
   localparam int HOLD_AT     = 250;     // sample count that starts the receiver hold-off
   localparam int HOLD_CYCLES = 1200;    // longer than two windows plus the root latency
   localparam int PAUSE_AT    = 1100;    // random sample index where the sender drains
   localparam int BURST_LO    = 500;     // sender runs without gaps for these samples
   localparam int BURST_HI    = 800;
   localparam int RCV_BURST_LO = 15000;  // receiver runs without gaps for these cycles
   localparam int RCV_BURST_HI = 22000;
   localparam int DIR_ROWS    = 9;

   typedef enum int {
      MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_NEAR_FULL, MIX_ONE_BIT
   } sample_mix_type;

   // One table row: a sample repeated reps times; typed rows carry the result
   // caused by their last repetition.
   typedef struct packed {
      trms_pkg::sample_type  sample;
      logic [10:0]           reps;
      logic                  typed;
      trms_pkg::rms_type     rms;
   } dir_row_type;

   logic clock;
   logic reset;

   trms_req_if req_ch();
   trms_rsp_if rsp_ch();

   true_rms_window_unit #(.NUM_SAMPLES(WIN)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dir_row_type        dir_tab [DIR_ROWS];
   trms_pkg::rms_type  rms_due_q [$];
   trms_pkg::rms_type  due_rms;
   logic [47:0]        sq_sum;
   int unsigned        sq_cnt;
   int                 err_cnt   = 0;
   int                 word_cnt  = 0;
   int                 cycle_cnt = 0;

   // Free-running clock, 4 ns period
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input trms_pkg::rms_type got,
                                  input trms_pkg::rms_type want);
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
      err_cnt++;
   endtask

   // Floor square root, one root bit per trial from the top down
   function automatic trms_pkg::rms_type floor_root(input logic [47:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= {16'd0, n}) root = trial;
      end
      return root[15:0];
   endfunction

   // Accumulate one sample; close the window when the count reaches its length
   task automatic rms_predict(input trms_pkg::sample_type s, output bit done,
                              output trms_pkg::rms_type val);
      int          v;
      logic [47:0] mag;
      int unsigned len;
      v    = s;
      mag  = 48'(v < 0 ? -v : v);
      len  = (WIN < 1) ? 1 : WIN;
      done = 1'b0;
      val  = '0;
      sq_sum = sq_sum + mag * mag;
      sq_cnt++;
      if (sq_cnt >= len) begin
         val    = floor_root(sq_sum / len);
         sq_sum = '0;
         sq_cnt = 0;
         done   = 1'b1;
      end
   endtask

   function automatic trms_pkg::sample_type pick_sample(input sample_mix_type mix);
      int v;
      case (mix)
         MIX_SMALL: begin
            v = int'($urandom_range(0, 511)) - 256;
         end
         MIX_EXTREME: begin
            case ($urandom_range(3))
               0: v = -32768;
               1: v = 32767;
               2: v = -32767;
               default: v = 0;
            endcase
         end
         MIX_NEAR_FULL: begin
            v = int'($urandom_range(32000, 32767));
            if ($urandom_range(1)) v = -v - int'($urandom_range(1));
         end
         MIX_ONE_BIT: begin
            v = 1 << $urandom_range(0, 14);
            if ($urandom_range(1)) v = -v;
         end
         default: begin
            v = int'($urandom_range(0, 65535));
         end
      endcase
      return trms_pkg::sample_type'(v);
   endfunction

   // Offer one sample word from a falling edge; hold it until taken
   task automatic send_word(input trms_pkg::sample_type s, input bit typed,
                            input trms_pkg::rms_type typed_rms);
      bit                 done;
      trms_pkg::rms_type  val;
      while (!(word_cnt >= BURST_LO && word_cnt < BURST_HI) &&
             $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      rms_predict(s, done, val);
      if (done) rms_due_q.push_back(typed ? typed_rms : val);
      word_cnt++;
      @(negedge clock);
   endtask

   // Sender: reset, table, random windows, final drain
   initial begin
      sample_mix_type mix;
      int             n;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      sq_sum        = '0;
      sq_cnt        = 0;
      mix           = MIX_FULL;
      n             = 0;
      // First row: a full window of the most negative sample
      dir_tab = '{
         '{trms_pkg::sample_type'(-32768), 11'd16, 1'b1, trms_pkg::rms_type'(32768)},
         '{trms_pkg::sample_type'(32767),  11'd1,  1'b0, trms_pkg::rms_type'(0)},
         '{trms_pkg::sample_type'(-32767), 11'd1,  1'b0, trms_pkg::rms_type'(0)},
         '{trms_pkg::sample_type'(0),      11'd1,  1'b0, trms_pkg::rms_type'(0)},
         '{trms_pkg::sample_type'(1),      11'd1,  1'b0, trms_pkg::rms_type'(0)},
         '{trms_pkg::sample_type'(-1),     11'd1,  1'b0, trms_pkg::rms_type'(0)},
         '{trms_pkg::sample_type'(21845),  11'd1,  1'b0, trms_pkg::rms_type'(0)},
         '{trms_pkg::sample_type'(-21846), 11'd1,  1'b0, trms_pkg::rms_type'(0)},
         '{trms_pkg::sample_type'(256),    11'd1,  1'b0, trms_pkg::rms_type'(0)}
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the table
      for (int r = 0; r < DIR_ROWS; r++) begin
         for (int k = 0; k < int'(dir_tab[r].reps); k++) begin
            send_word(dir_tab[r].sample, dir_tab[r].typed && (k == int'(dir_tab[r].reps) - 1),
                      dir_tab[r].rms);
         end
      end

      // Random windows; pick a new sample mix at each window start
      while (n < RAND_ITEMS || sq_cnt != 0) begin
         if (sq_cnt == 0) mix = sample_mix_type'($urandom_range(0, 4));
         if (n == PAUSE_AT) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
            while (rms_due_q.size() != 0) @(negedge clock);
         end
         send_word(pick_sample(mix), 1'b0, '0);
         n++;
      end

      // Drop valid, wait for the last results, then let the pipe settle
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (rms_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (err_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Receiver: random ready, one long hold-off, one gap-free stretch
   initial begin
      int rcv_cycles;
      int hold_left;
      bit hold_done;
      rcv_cycles   = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rcv_cycles++;
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && word_cnt >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rcv_cycles >= RCV_BURST_LO && rcv_cycles < RCV_BURST_HI) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Check each taken result word against the oldest one due; bound the run
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
         $display("[%0t] run exceeded %0d cycles", $realtime, LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rms_due_q.size() == 0) begin
            report_mismatch("result word with nothing due", rsp_ch.rms_value, '0);
         end else begin
            due_rms = rms_due_q.pop_front();
            if (rsp_ch.rms_value !== due_rms)
               report_mismatch("rms_value", rsp_ch.rms_value, due_rms);
         end
      end
   end

endmodule

/* sim.f */
rtl/trms_pkg.sv
rtl/trms_req_if.sv
rtl/trms_rsp_if.sv
rtl/true_rms_window_unit.sv
sim/tb_top.sv
